### rtl/core/fpsm_pkg.sv
`timescale 1ns / 1ps

package fpsm_pkg;

  // Sample and output formats.
  localparam int SAMPLE_BITS  = 16;
  localparam int DB_FRAC_BITS = 8;
  localparam int RAW_W        = 16;
  localparam int SMP_W        = SAMPLE_BITS + 1;
  localparam int DIF_W        = SAMPLE_BITS + 2;
  localparam int SQ_W         = 2 * SAMPLE_BITS;

  localparam int FS_W   = 21;
  localparam int PK_W   = 16;
  localparam int ST_W   = 2;
  localparam int FN_W   = 32;
  localparam int CNT_W  = 40;
  localparam int SUM_W  = 63;
  localparam int MSE_W  = 48;
  localparam int RMSE_W = 32;
  localparam int DB_W   = 16;

  // Divider, square root and logarithm sizes.
  localparam int DVD_W      = SUM_W + 16;
  localparam int DIV_STEPS  = DVD_W;
  localparam int SQRT_STEPS = RMSE_W;
  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = 6 + LOG_FRAC;
  localparam int LOGS_W     = LOG_W + 1;
  localparam int ITER_W     = 7;
  localparam int PROD_W     = LOGS_W + 30;
  localparam int DB_SHIFT   = LOG_FRAC + 28 - DB_FRAC_BITS;

  localparam logic [29:0]       TEN_LOG10_2 = 30'd808071242;
  localparam logic [PROD_W:0]   DB_RND      = (PROD_W + 1)'(1) << (DB_SHIFT - 1);
  localparam logic [PROD_W:0]   DB_POS_MAX  = (PROD_W + 1)'(32767);
  localparam logic [PROD_W:0]   DB_NEG_MAG  = (PROD_W + 1)'(32768);
  localparam logic [DB_W-1:0]   DB_ONE      = DB_W'(1) << DB_FRAC_BITS;
  localparam logic [DB_W-1:0]   DB_FLOOR    = 16'h8000;

  // Register map (index taken from paddr[3:2]).
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_FRAME_SAMPLES = 2'd0;
  localparam logic [1:0] REG_PEAK_VALUE    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_TYPE   = 2'd2;

  localparam logic [FS_W-1:0] FS_RESET = FS_W'(152064);
  localparam logic [PK_W-1:0] PK_RESET = PK_W'(255);
  localparam logic [ST_W-1:0] ST_RESET = '0;

  // Result beat layout in out_tdata.
  localparam int OFF_FN    = 0;
  localparam int OFF_CNT   = OFF_FN + FN_W;
  localparam int OFF_EA    = OFF_CNT + CNT_W;
  localparam int OFF_EB    = OFF_EA + SUM_W;
  localparam int OFF_ERR   = OFF_EB + SUM_W;
  localparam int OFF_MSE   = OFF_ERR + SUM_W;
  localparam int OFF_RMSE  = OFF_MSE + MSE_W;
  localparam int OFF_SNR   = OFF_RMSE + RMSE_W;
  localparam int OFF_PSNR  = OFF_SNR + DB_W;
  localparam int OFF_ID    = OFF_PSNR + DB_W;
  localparam int OUT_BITS  = OFF_ID + 1;
  localparam int OUT_TD_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_TD_W   = 2 * RAW_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_CHK, S_DIV, S_MSE, S_SQRT, S_LLOAD, S_LNORM,
    S_LITER, S_LSTORE, S_DB1, S_DB2, S_OUT, S_NEXT
  } state_t;

  typedef enum logic [1:0] {LS_ERR, LS_EA, LS_PK, LS_CNT} log_sel_t;

  typedef struct packed {
    logic     take;
    logic     accum;
    logic     snap_frame;
    logic     snap_total;
    logic     zero_set;
    logic     div_load;
    logic     div_step;
    logic     mse_set;
    logic     sqrt_step;
    logic     log_load;
    logic     log_norm;
    logic     log_step;
    logic     log_store;
    log_sel_t log_sel;
    logic     db_mul;
    logic     db_fin;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic more_results;
    logic zero_path;
    logic ea_zero;
    logic pk_zero;
    logic norm_top;
  } sts_t;

endpackage

### rtl/core/fpsm_ctrl.sv
`timescale 1ns / 1ps

module fpsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  fpsm_pkg::sts_t sts,
  output fpsm_pkg::cmd_t cmd
);
  import fpsm_pkg::*;

  state_t              state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  log_sel_t            sel_r, sel_nxt;

  // State, step counter and operand select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      sel_r   <= LS_ERR;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    iter_nxt    = iter_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.log_sel = sel_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (sts.frame_end) begin
          cmd.snap_frame = 1'b1;
          state_nxt      = S_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.zero_path) begin
          cmd.zero_set = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.div_load = 1'b1;
          iter_nxt     = ITER_W'(DIV_STEPS - 1);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (iter_r == '0) state_nxt = S_MSE;
        else              iter_nxt  = iter_r - 1'b1;
      end
      S_MSE: begin
        cmd.mse_set = 1'b1;
        iter_nxt    = ITER_W'(SQRT_STEPS - 1);
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter_r == '0) begin
          sel_nxt   = LS_ERR;
          state_nxt = S_LLOAD;
        end else begin
          iter_nxt = iter_r - 1'b1;
        end
      end
      S_LLOAD: begin
        cmd.log_load = 1'b1;
        state_nxt    = S_LNORM;
      end
      S_LNORM: begin
        cmd.log_norm = 1'b1;
        if (sts.norm_top) begin
          iter_nxt  = ITER_W'(LOG_FRAC - 1);
          state_nxt = S_LITER;
        end
      end
      S_LITER: begin
        cmd.log_step = 1'b1;
        if (iter_r == '0) state_nxt = S_LSTORE;
        else              iter_nxt  = iter_r - 1'b1;
      end
      S_LSTORE: begin
        cmd.log_store = 1'b1;
        state_nxt     = S_DB1;
        // Logs with a zero argument are skipped; the dB stage floors them.
        case (sel_r)
          LS_ERR: begin
            if (!sts.ea_zero) begin
              sel_nxt   = LS_EA;
              state_nxt = S_LLOAD;
            end else if (!sts.pk_zero) begin
              sel_nxt   = LS_PK;
              state_nxt = S_LLOAD;
            end
          end
          LS_EA: begin
            if (!sts.pk_zero) begin
              sel_nxt   = LS_PK;
              state_nxt = S_LLOAD;
            end
          end
          LS_PK: begin
            sel_nxt   = LS_CNT;
            state_nxt = S_LLOAD;
          end
          default: state_nxt = S_DB1;
        endcase
      end
      S_DB1: begin
        cmd.db_mul = 1'b1;
        state_nxt  = S_DB2;
      end
      S_DB2: begin
        cmd.db_fin = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = sts.more_results ? S_NEXT : S_IDLE;
      end
      S_NEXT: begin
        cmd.snap_total = 1'b1;
        state_nxt      = S_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/core/fpsm_dp.sv
`timescale 1ns / 1ps

module fpsm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [fpsm_pkg::FS_W-1:0]       frame_samples,
  input  logic [fpsm_pkg::PK_W-1:0]       peak_value,
  input  logic [fpsm_pkg::ST_W-1:0]       sample_type,
  input  logic [fpsm_pkg::RAW_W-1:0]      sample_a,
  input  logic [fpsm_pkg::RAW_W-1:0]      sample_b,
  input  logic                            end_of_stream,
  input  fpsm_pkg::cmd_t                  cmd,
  output fpsm_pkg::sts_t                  sts,
  output logic                            is_total,
  output logic                            is_last,
  output logic [fpsm_pkg::FN_W-1:0]       frame_number,
  output logic [fpsm_pkg::CNT_W-1:0]      sample_count,
  output logic [fpsm_pkg::SUM_W-1:0]      orig_energy,
  output logic [fpsm_pkg::SUM_W-1:0]      recon_energy,
  output logic [fpsm_pkg::SUM_W-1:0]      error_energy,
  output logic [fpsm_pkg::MSE_W-1:0]      mean_sq_error,
  output logic [fpsm_pkg::RMSE_W-1:0]     root_mean_sq_error,
  output logic [fpsm_pkg::DB_W-1:0]       snr_decibels,
  output logic [fpsm_pkg::DB_W-1:0]       psnr_decibels,
  output logic                            identical
);
  import fpsm_pkg::*;

  function automatic logic signed [SMP_W-1:0] decode(input logic [RAW_W-1:0] raw,
                                                     input logic [ST_W-1:0] st);
    logic signed [SMP_W-1:0] v;
    if (!st[1]) begin
      if (st[0]) v = {{(SMP_W-8){raw[7]}}, raw[7:0]};
      else       v = {{(SMP_W-8){1'b0}}, raw[7:0]};
    end else begin
      if (st[0]) v = {raw[SAMPLE_BITS-1], raw[SAMPLE_BITS-1:0]};
      else       v = {1'b0, raw[SAMPLE_BITS-1:0]};
    end
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [SQ_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(v);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [DB_W-1:0] db_round(input logic [PROD_W-1:0] prod,
                                               input logic neg);
    logic [PROD_W:0] s;
    logic [PROD_W:0] r;
    s = {1'b0, prod} + DB_RND;
    r = s >> DB_SHIFT;
    if (!neg) return (r > DB_POS_MAX) ? 16'h7FFF : r[DB_W-1:0];
    if (r > DB_NEG_MAG) r = DB_NEG_MAG;
    return -r[DB_W-1:0];
  endfunction

  // Decoded samples and their squares.
  logic signed [SMP_W-1:0]   a_s, b_s;
  logic signed [DIF_W-1:0]   d_s;
  logic signed [2*SMP_W-1:0] pa, pb;
  logic signed [2*DIF_W-1:0] pd;
  logic [SQ_W-1:0]           sq_a_r, sq_b_r, sq_d_r;
  logic                      eos_r;

  assign a_s = decode(sample_a, sample_type);
  assign b_s = decode(sample_b, sample_type);
  assign d_s = DIF_W'(a_s) - DIF_W'(b_s);
  assign pa  = a_s * a_s;
  assign pb  = b_s * b_s;
  assign pd  = d_s * d_s;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_a_r <= pa[SQ_W-1:0];
      sq_b_r <= pb[SQ_W-1:0];
      sq_d_r <= pd[SQ_W-1:0];
      eos_r  <= end_of_stream;
    end
  end

  // Accumulators, frame fill and counters.
  logic [SUM_W-1:0] fa_r, fb_r, fe_r, ta_r, tb_r, te_r;
  logic [SUM_W-1:0] fa_nxt, fb_nxt, fe_nxt, ta_nxt, tb_nxt, te_nxt;
  logic [FS_W-1:0]  fill_r, fill_nxt, limit;
  logic [FN_W-1:0]  fcnt_r;
  logic [CNT_W-1:0] tcnt_r, tcnt_nxt;

  assign fa_nxt   = sat_add(fa_r, sq_a_r);
  assign fb_nxt   = sat_add(fb_r, sq_b_r);
  assign fe_nxt   = sat_add(fe_r, sq_d_r);
  assign ta_nxt   = sat_add(ta_r, sq_a_r);
  assign tb_nxt   = sat_add(tb_r, sq_b_r);
  assign te_nxt   = sat_add(te_r, sq_d_r);
  assign fill_nxt = (&fill_r) ? fill_r : fill_r + 1'b1;
  assign tcnt_nxt = (&tcnt_r) ? tcnt_r : tcnt_r + 1'b1;
  assign limit    = (frame_samples == '0) ? FS_W'(1) : frame_samples;

  // Operands of the result under way.
  logic             res_total_r, res_last_r;
  logic [FN_W-1:0]  res_fn_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic [SUM_W-1:0] res_ea_r, res_eb_r, res_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r   <= '0;
      fb_r   <= '0;
      fe_r   <= '0;
      ta_r   <= '0;
      tb_r   <= '0;
      te_r   <= '0;
      fill_r <= '0;
      fcnt_r <= '0;
      tcnt_r <= '0;
    end else if (cmd.accum) begin
      ta_r   <= ta_nxt;
      tb_r   <= tb_nxt;
      te_r   <= te_nxt;
      tcnt_r <= tcnt_nxt;
      if (cmd.snap_frame) begin
        fa_r   <= '0;
        fb_r   <= '0;
        fe_r   <= '0;
        fill_r <= '0;
        fcnt_r <= fcnt_r + 1'b1;
      end else begin
        fa_r   <= fa_nxt;
        fb_r   <= fb_nxt;
        fe_r   <= fe_nxt;
        fill_r <= fill_nxt;
      end
    end else if (cmd.snap_total) begin
      fa_r   <= '0;
      fb_r   <= '0;
      fe_r   <= '0;
      ta_r   <= '0;
      tb_r   <= '0;
      te_r   <= '0;
      fill_r <= '0;
      fcnt_r <= '0;
      tcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_frame) begin
      res_total_r <= 1'b0;
      res_last_r  <= ~eos_r;
      res_fn_r    <= fcnt_r;
      res_cnt_r   <= CNT_W'(fill_nxt);
      res_ea_r    <= fa_nxt;
      res_eb_r    <= fb_nxt;
      res_err_r   <= fe_nxt;
    end else if (cmd.snap_total) begin
      res_total_r <= 1'b1;
      res_last_r  <= 1'b1;
      res_fn_r    <= fcnt_r;
      res_cnt_r   <= tcnt_r;
      res_ea_r    <= ta_r;
      res_eb_r    <= tb_r;
      res_err_r   <= te_r;
    end
  end

  // Restoring divider: error * 2^16 / count, one quotient bit a cycle.
  logic [DVD_W-1:0] dvd_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W:0]   rem_sh, rem_sub;
  logic             rem_ge;
  logic [MSE_W-1:0] mse_r, mse_nxt;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, res_cnt_r};
  assign rem_sub = rem_sh - {1'b0, res_cnt_r};
  assign mse_nxt = (|dvd_r[DVD_W-1:MSE_W]) ? {MSE_W{1'b1}} : dvd_r[MSE_W-1:0];

  // Square root, two radicand bits a cycle.
  logic [2*RMSE_W-1:0] xs_r;
  logic [RMSE_W+1:0]   sq_rem_r, sq_rem_sh, sq_trial;
  logic [RMSE_W-1:0]   root_r;
  logic                sq_ge;

  assign sq_rem_sh = {sq_rem_r[RMSE_W-1:0], xs_r[2*RMSE_W-1 -: 2]};
  assign sq_trial  = {root_r, 2'b01};
  assign sq_ge     = sq_rem_sh >= sq_trial;

  // Logarithm: normalize a bit a cycle, then one squaring per fraction bit.
  logic [63:0]         x_r, x_sel;
  logic [5:0]          sh_r;
  logic [31:0]         m_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic [63:0]         m_sq;
  logic [32:0]         m_t;
  logic [LOG_W-1:0]    log_val, log_err_r, log_ea_r;
  logic [LOGS_W-1:0]   log_ps_r;
  logic [2*PK_W-1:0]   pk_sq;

  assign pk_sq   = peak_value * peak_value;
  assign m_sq    = m_r * m_r;
  assign m_t     = m_sq[63:31];
  assign log_val = {~sh_r, frac_r};

  always_comb begin
    case (cmd.log_sel)
      LS_ERR:  x_sel = 64'(res_err_r);
      LS_EA:   x_sel = 64'(res_ea_r);
      LS_PK:   x_sel = 64'(pk_sq);
      default: x_sel = 64'(res_cnt_r);
    endcase
  end

  // Decibel stage.
  logic              snr_neg, psnr_neg, snr_neg_r, psnr_neg_r;
  logic [LOGS_W-1:0] snr_mag, psnr_mag;
  logic [PROD_W-1:0] snr_prod_r, psnr_prod_r;
  logic [DB_W-1:0]   snr_r, psnr_r;
  logic              ident_r;

  assign snr_neg  = log_ea_r < log_err_r;
  assign snr_mag  = snr_neg ? LOGS_W'(log_err_r) - LOGS_W'(log_ea_r)
                            : LOGS_W'(log_ea_r) - LOGS_W'(log_err_r);
  assign psnr_neg = log_ps_r < LOGS_W'(log_err_r);
  assign psnr_mag = psnr_neg ? LOGS_W'(log_err_r) - log_ps_r
                             : log_ps_r - LOGS_W'(log_err_r);

  always_ff @(posedge clk) begin
    if (cmd.zero_set) begin
      mse_r   <= '0;
      root_r  <= '0;
      snr_r   <= DB_ONE;
      psnr_r  <= DB_ONE;
      ident_r <= (res_err_r == '0);
    end
    if (cmd.div_load) begin
      dvd_r   <= {res_err_r, 16'h0000};
      rem_r   <= '0;
      ident_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], rem_ge};
    end
    if (cmd.mse_set) begin
      mse_r    <= mse_nxt;
      xs_r     <= {mse_nxt, 16'h0000};
      sq_rem_r <= '0;
      root_r   <= '0;
    end
    if (cmd.sqrt_step) begin
      xs_r     <= {xs_r[2*RMSE_W-3:0], 2'b00};
      sq_rem_r <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
      root_r   <= {root_r[RMSE_W-2:0], sq_ge};
    end
    if (cmd.log_load) begin
      x_r    <= x_sel;
      sh_r   <= '0;
      frac_r <= '0;
    end
    if (cmd.log_norm) begin
      if (x_r[63]) begin
        m_r <= x_r[63:32];
      end else begin
        x_r  <= {x_r[62:0], 1'b0};
        sh_r <= sh_r + 1'b1;
      end
    end
    if (cmd.log_step) begin
      frac_r <= {frac_r[LOG_FRAC-2:0], m_t[32]};
      m_r    <= m_t[32] ? m_t[32:1] : m_t[31:0];
    end
    if (cmd.log_store) begin
      case (cmd.log_sel)
        LS_ERR:  log_err_r <= log_val;
        LS_EA:   log_ea_r  <= log_val;
        LS_PK:   log_ps_r  <= LOGS_W'(log_val);
        default: log_ps_r  <= log_ps_r + LOGS_W'(log_val);
      endcase
    end
    if (cmd.db_mul) begin
      snr_prod_r  <= snr_mag * TEN_LOG10_2;
      psnr_prod_r <= psnr_mag * TEN_LOG10_2;
      snr_neg_r   <= snr_neg;
      psnr_neg_r  <= psnr_neg;
    end
    if (cmd.db_fin) begin
      snr_r  <= (res_ea_r == '0) ? DB_FLOOR : db_round(snr_prod_r, snr_neg_r);
      psnr_r <= (peak_value == '0) ? DB_FLOOR : db_round(psnr_prod_r, psnr_neg_r);
    end
  end

  // Status back to the controller.
  assign sts.frame_end    = (fill_nxt >= limit) || eos_r;
  assign sts.more_results = eos_r && !res_total_r;
  assign sts.zero_path    = (res_err_r == '0) || (res_cnt_r == '0);
  assign sts.ea_zero      = (res_ea_r == '0);
  assign sts.pk_zero      = (peak_value == '0);
  assign sts.norm_top     = x_r[63];

  assign is_total           = res_total_r;
  assign is_last            = res_last_r;
  assign frame_number       = res_fn_r;
  assign sample_count       = res_cnt_r;
  assign orig_energy        = res_ea_r;
  assign recon_energy       = res_eb_r;
  assign error_energy       = res_err_r;
  assign mean_sq_error      = mse_r;
  assign root_mean_sq_error = root_r;
  assign snr_decibels       = snr_r;
  assign psnr_decibels      = psnr_r;
  assign identical          = ident_r;

endmodule

### rtl/core/frame_psnr_snr_meter.sv
`timescale 1ns / 1ps
// A sample pair that closes no frame is accepted, then accumulated.
// At a frame end the result follows a divide, a square root, up to four logarithms
// and the dB stage; the 79-step divider and the log normalizer take most of the time.
// A zero-error result skips the divide, root and logs. End of stream adds a totals beat.
// No new pair is taken until the last is accumulated, nor while a result is computed or held.
// Reset (synchronous, rst_n low) clears all sums and counters and restores register defaults.

module frame_psnr_snr_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fpsm_pkg::IN_TD_W-1:0]       in_tdata,  // sample_a, sample_b
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // frame_number, sample_count, orig_energy, recon_energy, error_energy, mean_sq_error,
  // root_mean_sq_error, snr_decibels, psnr_decibels, identical, zero fill
  output logic [fpsm_pkg::OUT_TD_W-1:0]      out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser, // is_total
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fpsm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import fpsm_pkg::*;

  logic [FS_W-1:0] frame_samples_r;
  logic [PK_W-1:0] peak_value_r;
  logic [ST_W-1:0] sample_type_r;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_samples_r <= FS_RESET;
      peak_value_r    <= PK_RESET;
      sample_type_r   <= ST_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_SAMPLES: frame_samples_r <= cfg_pwdata[FS_W-1:0];
        REG_PEAK_VALUE:    peak_value_r    <= cfg_pwdata[PK_W-1:0];
        REG_SAMPLE_TYPE:   sample_type_r   <= cfg_pwdata[ST_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_SAMPLES: cfg_prdata = 32'(frame_samples_r);
      REG_PEAK_VALUE:    cfg_prdata = 32'(peak_value_r);
      REG_SAMPLE_TYPE:   cfg_prdata = 32'(sample_type_r);
      default:           cfg_prdata = '0;
    endcase
  end

  cmd_t              cmd;
  sts_t              sts;
  logic [FN_W-1:0]   frame_number;
  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  orig_energy, recon_energy, error_energy;
  logic [MSE_W-1:0]  mean_sq_error;
  logic [RMSE_W-1:0] root_mean_sq_error;
  logic [DB_W-1:0]   snr_decibels, psnr_decibels;
  logic              identical;

  fpsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fpsm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame_samples      (frame_samples_r),
    .peak_value         (peak_value_r),
    .sample_type        (sample_type_r),
    .sample_a           (in_tdata[RAW_W-1:0]),
    .sample_b           (in_tdata[2*RAW_W-1:RAW_W]),
    .end_of_stream      (in_tlast),
    .cmd                (cmd),
    .sts                (sts),
    .is_total           (out_tuser),
    .is_last            (out_tlast),
    .frame_number       (frame_number),
    .sample_count       (sample_count),
    .orig_energy        (orig_energy),
    .recon_energy       (recon_energy),
    .error_energy       (error_energy),
    .mean_sq_error      (mean_sq_error),
    .root_mean_sq_error (root_mean_sq_error),
    .snr_decibels       (snr_decibels),
    .psnr_decibels      (psnr_decibels),
    .identical          (identical)
  );

  // Pack the result beat, first field in the low bits.
  always_comb begin
    out_tdata                      = '0;
    out_tdata[OFF_FN   +: FN_W]    = frame_number;
    out_tdata[OFF_CNT  +: CNT_W]   = sample_count;
    out_tdata[OFF_EA   +: SUM_W]   = orig_energy;
    out_tdata[OFF_EB   +: SUM_W]   = recon_energy;
    out_tdata[OFF_ERR  +: SUM_W]   = error_energy;
    out_tdata[OFF_MSE  +: MSE_W]   = mean_sq_error;
    out_tdata[OFF_RMSE +: RMSE_W]  = root_mean_sq_error;
    out_tdata[OFF_SNR  +: DB_W]    = snr_decibels;
    out_tdata[OFF_PSNR +: DB_W]    = psnr_decibels;
    out_tdata[OFF_ID]              = identical;
  end

endmodule

### rtl/core/fpsm_checker.sv
`timescale 1ns / 1ps

module fpsm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [fpsm_pkg::OUT_TD_W-1:0] out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);
  import fpsm_pkg::*;

  // A held result beat keeps its payload until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The meter never takes a pair while a result is waiting.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // The totals beat always closes the results of its pair.
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("totals beat without tlast");

  // Zero error reports the sentinel and a zero MSE.
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OFF_ID] |->
      out_tdata[OFF_SNR +: DB_W] == DB_ONE && out_tdata[OFF_PSNR +: DB_W] == DB_ONE
      && out_tdata[OFF_MSE +: MSE_W] == '0)
    else $error("identical beat without sentinel values");

endmodule

bind frame_psnr_snr_meter fpsm_checker u_fpsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### sim/frame_psnr_snr_meter_tb.sv
`timescale 1ns / 1ps

module frame_psnr_snr_meter_tb;
  import fpsm_pkg::*;

  localparam int LIMIT_CYCLES = 12_000_000;
  localparam int DRAIN_CYCLES = 800;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct {
    logic              is_total;
    logic              is_last;
    logic [FN_W-1:0]   frame_number;
    logic [CNT_W-1:0]  sample_count;
    logic [SUM_W-1:0]  orig_energy;
    logic [SUM_W-1:0]  recon_energy;
    logic [SUM_W-1:0]  error_energy;
    logic [MSE_W-1:0]  mean_sq_error;
    logic [RMSE_W-1:0] root_mean_sq_error;
    logic [DB_W-1:0]   snr_db;
    logic [DB_W-1:0]   psnr_db;
    logic              identical;
  } quality_t;

  localparam longint unsigned SUM_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned CNT_CAP = 64'hFF_FFFF_FFFF;
  localparam longint unsigned MSE_CAP = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned DB_GAIN = 64'd808071242;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TD_W-1:0]    in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_TD_W-1:0]   out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the block's registers and running sums.
  logic [FS_W-1:0]  m_frame_len;
  logic [PK_W-1:0]  m_peak;
  logic [ST_W-1:0]  m_type;
  longint unsigned  f_ea, f_eb, f_err, f_fill, f_index;
  longint unsigned  t_ea, t_eb, t_err, t_count;

  quality_t         pending_results[$];
  int               error_count;
  int               reg_error_count;
  int               cycle_count;
  bit               hold_request;
  bit               steady_flow;

  frame_psnr_snr_meter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mostly short gaps, now and then a long one; none while flow is steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned v);
    if (acc >= SUM_CAP || v > SUM_CAP - acc) return SUM_CAP;
    return acc + v;
  endfunction

  function automatic longint signed to_sample(logic [15:0] raw);
    longint unsigned width, mask, v;
    width = (m_type < 2) ? 64'd8 : 64'(SAMPLE_BITS);
    mask = (64'd1 << width) - 1;
    v = 64'(raw) & mask;
    if (m_type[0] && v[width-1]) return longint'(v) - longint'(mask + 1);
    return longint'(v);
  endfunction

  // Fixed-point log2 with LOG_FRAC fraction bits, by repeated squaring.
  function automatic longint unsigned log2_q(longint unsigned x);
    longint unsigned msb, m, frac;
    msb = 63;
    frac = 0;
    while (msb > 0 && !x[msb]) msb--;
    m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (msb << LOG_FRAC) | frac;
  endfunction

  function automatic logic [DB_W-1:0] decibels(longint unsigned num_l, longint unsigned den_l);
    bit neg;
    longint unsigned mag, r;
    neg = num_l < den_l;
    mag = neg ? den_l - num_l : num_l - den_l;
    r = (mag * DB_GAIN + (64'd1 << (DB_SHIFT - 1))) >> DB_SHIFT;
    if (!neg) return (r > 32767) ? 16'd32767 : r[15:0];
    if (r > 32768) r = 32768;
    return 16'(64'h10000 - r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic quality_t measure(bit total, bit last, longint unsigned fnum,
                                       longint unsigned cnt, longint unsigned ea,
                                       longint unsigned eb, longint unsigned err);
    quality_t q;
    longint unsigned quo, rem, mse, err_l, pk;
    q.is_total = total;
    q.is_last = last;
    q.frame_number = fnum[FN_W-1:0];
    q.sample_count = cnt[CNT_W-1:0];
    q.orig_energy = ea[SUM_W-1:0];
    q.recon_energy = eb[SUM_W-1:0];
    q.error_energy = err[SUM_W-1:0];
    q.identical = (err == 0);
    if (err == 0 || cnt == 0) begin
      q.mean_sq_error = '0;
      q.root_mean_sq_error = '0;
      q.snr_db = DB_ONE;
      q.psnr_db = DB_ONE;
    end else begin
      quo = err / cnt;
      rem = err % cnt;
      err_l = log2_q(err);
      mse = (quo >= (64'd1 << 32)) ? MSE_CAP : (quo << 16) + ((rem << 16) / cnt);
      q.mean_sq_error = mse[MSE_W-1:0];
      q.root_mean_sq_error = RMSE_W'(int_sqrt(mse << 16));
      q.snr_db = (ea != 0) ? decibels(log2_q(ea), err_l) : DB_FLOOR;
      pk = 64'(m_peak);
      q.psnr_db = (pk != 0) ? decibels(log2_q(pk * pk) + log2_q(cnt), err_l) : DB_FLOOR;
    end
    return q;
  endfunction

  // Accumulate one accepted pair and queue the results it closes.
  function automatic void predict_pair(logic [15:0] raw_a, logic [15:0] raw_b, bit eos);
    longint signed a, b, d;
    longint unsigned limit;
    a = to_sample(raw_a);
    b = to_sample(raw_b);
    d = a - b;
    limit = (m_frame_len == 0) ? 64'd1 : 64'(m_frame_len);
    f_ea = sat_sum(f_ea, a * a);
    f_eb = sat_sum(f_eb, b * b);
    f_err = sat_sum(f_err, d * d);
    t_ea = sat_sum(t_ea, a * a);
    t_eb = sat_sum(t_eb, b * b);
    t_err = sat_sum(t_err, d * d);
    if (f_fill < 64'h1F_FFFF) f_fill++;
    if (t_count < CNT_CAP) t_count++;
    if (f_fill >= limit || eos) begin
      pending_results.push_back(measure(0, !eos, f_index, f_fill, f_ea, f_eb, f_err));
      f_index = (f_index + 1) & 64'hFFFF_FFFF;
      f_ea = 0;
      f_eb = 0;
      f_err = 0;
      f_fill = 0;
    end
    if (eos) begin
      pending_results.push_back(measure(1, 1, f_index, t_count, t_ea, t_eb, t_err));
      f_index = 0;
      t_ea = 0;
      t_eb = 0;
      t_err = 0;
      t_count = 0;
    end
  endfunction

  // Offer one sample pair and hold it until the block takes it.
  task automatic send_pair(logic [15:0] raw_a, logic [15:0] raw_b, bit eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {raw_b, raw_a};
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    predict_pair(raw_a, raw_b, eos);
  endtask

  // Let every queued result drain, then the tail of a pair still in flight.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write followed by a read-back.
  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    logic [31:0] mask;
    mask = (index == REG_FRAME_SAMPLES) ? 32'h1F_FFFF :
           (index == REG_PEAK_VALUE) ? 32'hFFFF : 32'h3;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_FRAME_SAMPLES: m_frame_len = value[FS_W-1:0];
      REG_PEAK_VALUE:    m_peak = value[PK_W-1:0];
      default:           m_type = value[ST_W-1:0];
    endcase
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== (value & mask)) begin
      $error("register %0d: expected %0h, actual %0h", index, value & mask, cfg_prdata);
      reg_error_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(int unsigned frame_len, int unsigned peak, int unsigned kind);
    wait_idle();
    write_reg(REG_FRAME_SAMPLES, frame_len);
    write_reg(REG_PEAK_VALUE, peak);
    write_reg(REG_SAMPLE_TYPE, kind);
  endtask

  // Extremes, identical frames and stream ends on unsigned 8-bit data.
  task automatic test_unsigned_bytes();
    set_config(4, 255, 0);
    send_pair(16'h0000, 16'h0000, 0);
    send_pair(16'h00FF, 16'h00FF, 0);
    send_pair(16'h00FF, 16'h0000, 0);
    send_pair(16'hFF00, 16'h00FF, 0);
    repeat (4) send_pair(16'h0007, 16'h0007, 0);
    send_pair(16'h0001, 16'h0002, 1);
    // Stream end on a frame boundary.
    repeat (3) send_pair(16'h0010, 16'h0012, 0);
    send_pair(16'h0010, 16'h0012, 1);
  endtask

  // Signed 8-bit and both 16-bit sample types with their sign and width corner values.
  task automatic test_sample_types();
    set_config(2, 65535, 1);
    send_pair(16'hAB80, 16'h007F, 0);
    send_pair(16'h00FF, 16'h0080, 1);
    set_config(3, 1, 2);
    send_pair(16'hFFFF, 16'h0000, 0);
    send_pair(16'h8000, 16'h7FFF, 1);
    set_config(1, 255, 3);
    send_pair(16'h8000, 16'h7FFF, 0);
    send_pair(16'hFFFF, 16'h8000, 1);
  endtask

  // Zero original energy, zero peak, zero and huge frame lengths.
  task automatic test_corner_cases();
    set_config(2, 0, 0);
    send_pair(16'h0000, 16'h0005, 0);
    send_pair(16'h0000, 16'h0009, 0);
    set_config(0, 255, 0);
    send_pair(16'h0003, 16'h0001, 0);
    send_pair(16'h0003, 16'h0003, 1);
    set_config(1048576, 65535, 3);
    send_pair(16'h1234, 16'hFEDC, 0);
    send_pair(16'h8001, 16'h7FFE, 1);
    set_config(1, 255, 0);
    send_pair(16'h0042, 16'h0042, 1);
  endtask

  // Random streams under random settings, mostly short frames.
  task automatic test_random_streams(int unsigned pairs);
    int unsigned sent, phase_len, frame_len, peak;
    sent = 0;
    while (sent < pairs) begin
      frame_len = ($urandom_range(0, 9) == 0) ? 1048576 : $urandom_range(1, 40);
      peak = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(1, 65535);
      set_config(frame_len, peak, $urandom_range(0, 3));
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      for (int unsigned i = 0; i < phase_len; i++) begin
        send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  ($urandom_range(0, 39) == 0) || (i == phase_len - 1 && frame_len > 40));
        sent++;
      end
      steady_flow = 0;
    end
  endtask

  // The receiver holds off while pairs keep coming, so the block backs up.
  task automatic test_output_stall();
    set_config(3, 200, 2);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 0);
    end
    send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1);
  endtask

  // Result sink with random stalls and the long hold-off.
  always @(posedge clk) begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end
  end

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    quality_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("is_total", 64'(want.is_total), 64'(out_tuser));
        compare_field("is_last", 64'(want.is_last), 64'(out_tlast));
        compare_field("frame_number", 64'(want.frame_number),
                      64'(out_tdata[OFF_FN +: FN_W]));
        compare_field("sample_count", 64'(want.sample_count),
                      64'(out_tdata[OFF_CNT +: CNT_W]));
        compare_field("orig_energy", 64'(want.orig_energy),
                      64'(out_tdata[OFF_EA +: SUM_W]));
        compare_field("recon_energy", 64'(want.recon_energy),
                      64'(out_tdata[OFF_EB +: SUM_W]));
        compare_field("error_energy", 64'(want.error_energy),
                      64'(out_tdata[OFF_ERR +: SUM_W]));
        compare_field("mean_sq_error", 64'(want.mean_sq_error),
                      64'(out_tdata[OFF_MSE +: MSE_W]));
        compare_field("root_mean_sq_error", 64'(want.root_mean_sq_error),
                      64'(out_tdata[OFF_RMSE +: RMSE_W]));
        compare_field("snr_decibels", 64'(want.snr_db),
                      64'(out_tdata[OFF_SNR +: DB_W]));
        compare_field("psnr_decibels", 64'(want.psnr_db),
                      64'(out_tdata[OFF_PSNR +: DB_W]));
        compare_field("identical", 64'(want.identical), 64'(out_tdata[OFF_ID]));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("frame_psnr_snr_meter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_request = 1'b0;
    reg_error_count = 0;
    steady_flow = 0;
    m_frame_len = FS_RESET;
    m_peak = PK_RESET;
    m_type = ST_RESET;
    f_ea = 0; f_eb = 0; f_err = 0; f_fill = 0; f_index = 0;
    t_ea = 0; t_eb = 0; t_err = 0; t_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults hold for a short stream first.
    send_pair(16'h0080, 16'h0081, 1);
    test_unsigned_bytes();
    test_sample_types();
    test_corner_cases();
    test_output_stall();
    test_random_streams(1600);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && reg_error_count == 0 && pending_results.size() == 0) begin
      $display("frame_psnr_snr_meter_tb: done, clean");
    end else begin
      $display("frame_psnr_snr_meter_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/fpsm_pkg.sv
rtl/core/fpsm_ctrl.sv
rtl/core/fpsm_dp.sv
rtl/core/frame_psnr_snr_meter.sv
rtl/core/fpsm_checker.sv
sim/frame_psnr_snr_meter_tb.sv
